### design/sdis_pkg.sv
// Shared types and constants for the SD/MMC card identification sequencer.
// No dependencies; imported by sdis_core, sd_card_init_sequencer_unit and the testbench.
package sdis_pkg;

    // Item codes
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // Command indices
    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SEND_OP   = 6'd1;
    localparam logic [5:0] CMD_ALL_CID   = 6'd2;
    localparam logic [5:0] CMD_SET_RCA   = 6'd3;
    localparam logic [5:0] CMD_BUS_WIDTH = 6'd6;
    localparam logic [5:0] CMD_SELECT    = 6'd7;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
    localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
    localparam logic [5:0] CMD_SD_OP     = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;

    // Response kinds
    localparam logic [1:0] RESP_NONE  = 2'd0;
    localparam logic [1:0] RESP_SHORT = 2'd1;
    localparam logic [1:0] RESP_LONG  = 2'd2;

    // Capture hints
    localparam logic [1:0] CAP_NONE = 2'd0;
    localparam logic [1:0] CAP_OCR  = 2'd1;
    localparam logic [1:0] CAP_CID  = 2'd2;
    localparam logic [1:0] CAP_CSD  = 2'd3;

    // Card kinds
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_MMC     = 2'd1;
    localparam logic [1:0] KIND_SD1     = 2'd2;
    localparam logic [1:0] KIND_SD2     = 2'd3;

    // Arguments and masks
    localparam logic [31:0] IF_COND_ARG    = 32'h0000_01AA;
    localparam logic [11:0] IF_COND_ECHO   = 12'h1AA;
    localparam logic [31:0] HCS_OP_ARG     = 32'h4002_0000;
    localparam logic [31:0] VOLT_WINDOW    = 32'h00FF_8000;
    localparam logic [31:0] BUS_4BIT_ARG   = 32'h0000_0002;
    localparam logic [31:0] BLOCK_LEN_ARG  = 32'd512;
    localparam logic [31:0] STATUS_ERR_MSK = 32'hFDF9_0000;
    localparam int          OCR_BUSY_BIT   = 31;
    localparam int          OCR_CCS_BIT    = 30;
    localparam int          APP_CMD_BIT    = 5;
    localparam logic [15:0] MMC_RCA        = 16'h0001;

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd100;

    typedef struct packed {
        logic        action;
        logic        cmd_sent;
        logic        resp_end;
        logic        crc_fail;
        logic [31:0] resp_word0;
    } item_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [1:0]  resp_kind;
        logic [1:0]  capture_kind;
        logic        done_res;
        logic        failed;
        logic [1:0]  card_kind;
        logic        block_addressing;
        logic [15:0] card_address;
        logic        wide_bus;
    } result_t;

endpackage

### design/sdis_core.sv
// Identification state machine: holds the sequencer state and decides the next
// command for each transfer. Depends on sdis_pkg.
module sdis_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  sdis_pkg::item_t item,
    input  logic [7:0]      retry_limit,
    output sdis_pkg::result_t res
);
    import sdis_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD0, PH_CMD8, PH_POLL2, PH_PROBE, PH_POLL1,
        PH_CMD2, PH_CMD3, PH_CMD9, PH_CMD7, PH_CMD16, PH_ACMD6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        app_reg, app_next;
    logic [7:0]  attempt_reg, attempt_next;
    logic [1:0]  kind_reg, kind_next;
    logic        block_reg, block_next;
    logic [15:0] rca_reg, rca_next;
    logic        cmd1_reg, cmd1_next;
    logic        wide_reg, wide_next;

    logic        ok;
    logic        do_handle;
    logic        crc_tolerant;
    logic        sd;
    logic        status_bad;
    logic [5:0]  acmd_idx;
    logic [31:0] acmd_arg;

    always_comb
    begin
        sd         = kind_reg[1];
        status_bad = |(item.resp_word0 & STATUS_ERR_MSK);
        acmd_idx   = (phase_reg == PH_ACMD6) ? CMD_BUS_WIDTH : CMD_SD_OP;
        if (phase_reg == PH_POLL2)
            acmd_arg = HCS_OP_ARG;
        else if (phase_reg == PH_ACMD6)
            acmd_arg = BUS_4BIT_ARG;
        else
            acmd_arg = VOLT_WINDOW;
        // CMD41 and CMD1 responses carry no valid CRC
        crc_tolerant = (phase_reg == PH_POLL2) || (phase_reg == PH_PROBE) ||
                       (phase_reg == PH_POLL1);

        phase_next   = phase_reg;
        app_next     = app_reg;
        attempt_next = attempt_reg;
        kind_next    = kind_reg;
        block_next   = block_reg;
        rca_next     = rca_reg;
        cmd1_next    = cmd1_reg;
        wide_next    = wide_reg;

        res = '0;
        ok = 1'b0;
        do_handle = 1'b0;

        if (item.action == ACT_START)
        begin
            phase_next   = PH_CMD0;
            app_next     = 1'b0;
            attempt_next = '0;
            kind_next    = KIND_UNKNOWN;
            block_next   = 1'b0;
            rca_next     = '0;
            cmd1_next    = 1'b0;
            wide_next    = 1'b0;
            res.cmd_valid = 1'b1;
            res.cmd_index = CMD_GO_IDLE;
            res.cmd_arg   = '0;
            res.resp_kind = RESP_NONE;
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (app_reg)
            begin
                app_next = 1'b0;
                if (item.resp_end && item.resp_word0[APP_CMD_BIT])
                begin
                    res.cmd_valid = 1'b1;
                    res.cmd_index = acmd_idx;
                    res.cmd_arg   = acmd_arg;
                    res.resp_kind = RESP_SHORT;
                end
                else
                    do_handle = 1'b1;   // prefix failed: the ACMD counts as failed
            end
            else
            begin
                do_handle = 1'b1;
                if (phase_reg == PH_CMD0)
                    ok = item.cmd_sent;
                else
                    ok = item.resp_end || (item.crc_fail && crc_tolerant);
            end
        end

        if (do_handle)
        begin
            unique case (phase_reg)
                PH_CMD0:
                begin
                    phase_next    = PH_CMD8;
                    res.cmd_valid = 1'b1;
                    res.cmd_index = CMD_IF_COND;
                    res.cmd_arg   = IF_COND_ARG;
                    res.resp_kind = RESP_SHORT;
                end
                PH_CMD8:
                begin
                    if (ok && item.resp_word0[11:0] == IF_COND_ECHO)
                    begin
                        kind_next    = KIND_SD2;
                        phase_next   = PH_POLL2;
                        attempt_next = 8'd1;
                        app_next     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PROBE;
                        app_next   = 1'b1;
                    end
                    res.cmd_valid = 1'b1;
                    res.cmd_index = CMD_APP;
                    res.cmd_arg   = {rca_reg, 16'h0000};
                    res.resp_kind = RESP_SHORT;
                end
                PH_PROBE:
                begin
                    kind_next    = ok ? KIND_SD1 : KIND_MMC;
                    cmd1_next    = !ok;
                    phase_next   = PH_POLL1;
                    attempt_next = 8'd1;
                    res.cmd_valid = 1'b1;
                    res.resp_kind = RESP_SHORT;
                    if (ok)
                    begin
                        app_next      = 1'b1;
                        res.cmd_index = CMD_APP;
                        res.cmd_arg   = {rca_reg, 16'h0000};
                    end
                    else
                    begin
                        res.cmd_index = CMD_SEND_OP;
                        res.cmd_arg   = VOLT_WINDOW;
                    end
                end
                PH_POLL2, PH_POLL1:
                begin
                    if (ok && item.resp_word0[OCR_BUSY_BIT])
                    begin
                        if (phase_reg == PH_POLL2)
                            block_next = item.resp_word0[OCR_CCS_BIT];
                        res.capture_kind = CAP_OCR;
                        phase_next    = PH_CMD2;
                        res.cmd_valid = 1'b1;
                        res.cmd_index = CMD_ALL_CID;
                        res.cmd_arg   = '0;
                        res.resp_kind = RESP_LONG;
                    end
                    else if (attempt_reg >= retry_limit)
                    begin
                        phase_next   = PH_IDLE;
                        app_next     = 1'b0;
                        res.done_res = 1'b1;
                        res.failed   = 1'b1;
                    end
                    else
                    begin
                        attempt_next  = attempt_reg + 8'd1;
                        res.cmd_valid = 1'b1;
                        res.resp_kind = RESP_SHORT;
                        if (phase_reg == PH_POLL1 && cmd1_reg)
                        begin
                            res.cmd_index = CMD_SEND_OP;
                            res.cmd_arg   = VOLT_WINDOW;
                        end
                        else
                        begin
                            app_next      = 1'b1;
                            res.cmd_index = CMD_APP;
                            res.cmd_arg   = {rca_reg, 16'h0000};
                        end
                    end
                end
                PH_CMD2, PH_CMD3, PH_CMD9, PH_CMD7, PH_CMD16, PH_ACMD6:
                begin
                    if (!ok || ((phase_reg == PH_CMD16 || phase_reg == PH_ACMD6) && status_bad))
                    begin
                        phase_next   = PH_IDLE;
                        app_next     = 1'b0;
                        res.done_res = 1'b1;
                        res.failed   = 1'b1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_CMD2:
                            begin
                                res.capture_kind = CAP_CID;
                                phase_next    = PH_CMD3;
                                res.cmd_valid = 1'b1;
                                res.cmd_index = CMD_SET_RCA;
                                res.cmd_arg   = sd ? 32'h0 : {MMC_RCA, 16'h0000};
                                res.resp_kind = RESP_SHORT;
                            end
                            PH_CMD3:
                            begin
                                rca_next      = sd ? item.resp_word0[31:16] : MMC_RCA;
                                phase_next    = PH_CMD9;
                                res.cmd_valid = 1'b1;
                                res.cmd_index = CMD_SEND_CSD;
                                res.cmd_arg   = {rca_next, 16'h0000};
                                res.resp_kind = RESP_LONG;
                            end
                            PH_CMD9:
                            begin
                                res.capture_kind = CAP_CSD;
                                phase_next    = PH_CMD7;
                                res.cmd_valid = 1'b1;
                                res.cmd_index = CMD_SELECT;
                                res.cmd_arg   = {rca_reg, 16'h0000};
                                res.resp_kind = RESP_SHORT;
                            end
                            PH_CMD7, PH_CMD16:
                            begin
                                if (phase_reg == PH_CMD7 && !block_reg)
                                begin
                                    phase_next    = PH_CMD16;
                                    res.cmd_valid = 1'b1;
                                    res.cmd_index = CMD_BLOCKLEN;
                                    res.cmd_arg   = BLOCK_LEN_ARG;
                                    res.resp_kind = RESP_SHORT;
                                end
                                else if (sd)
                                begin
                                    phase_next    = PH_ACMD6;
                                    app_next      = 1'b1;
                                    res.cmd_valid = 1'b1;
                                    res.cmd_index = CMD_APP;
                                    res.cmd_arg   = {rca_reg, 16'h0000};
                                    res.resp_kind = RESP_SHORT;
                                end
                                else
                                begin
                                    phase_next   = PH_IDLE;
                                    app_next     = 1'b0;
                                    res.done_res = 1'b1;
                                end
                            end
                            default:
                            begin
                                // bus width switch accepted
                                wide_next    = 1'b1;
                                phase_next   = PH_IDLE;
                                app_next     = 1'b0;
                                res.done_res = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        res.card_kind        = kind_next;
        res.block_addressing = block_next;
        res.card_address     = rca_next;
        res.wide_bus         = wide_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            app_reg     <= 1'b0;
            attempt_reg <= '0;
            kind_reg    <= KIND_UNKNOWN;
            block_reg   <= 1'b0;
            rca_reg     <= '0;
            cmd1_reg    <= 1'b0;
            wide_reg    <= 1'b0;
        end
        else if (en)
        begin
            phase_reg   <= phase_next;
            app_reg     <= app_next;
            attempt_reg <= attempt_next;
            kind_reg    <= kind_next;
            block_reg   <= block_next;
            rca_reg     <= rca_next;
            cmd1_reg    <= cmd1_next;
            wide_reg    <= wide_next;
        end
    end

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (en && item.action == ACT_START) |=>
            (phase_reg == PH_CMD0 && attempt_reg == 8'd0 && !app_reg && !wide_reg))
        else $error("start did not restart the sequence");

    a_app_phase: assert property (@(posedge clk) disable iff (!rst_n)
        app_reg |-> (phase_reg == PH_POLL2 || phase_reg == PH_POLL1 ||
                     phase_reg == PH_PROBE || phase_reg == PH_ACMD6))
        else $error("CMD55 prefix pending outside an ACMD phase");

    a_cmd1_mmc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd1_reg |-> (kind_reg == KIND_MMC))
        else $error("CMD1 polling on a card that is not MMC");

endmodule

### design/sd_card_init_sequencer_unit.sv
// SD/MMC card identification sequencer, top level: input and result registers
// around the decision logic. Depends on sdis_pkg and sdis_core.
//
// One completion (or start) transfer in, one next-command result out. The
// block takes one item per cycle unless back-pressure holds it; each item
// passes the input register, then the single-pass decision in sdis_core into
// the result register. Back-pressure on the result side stalls the input side
// only once both registers are full. The user must write retry_limit through
// cfg_wr_en/cfg_wr_data only while no transfer is in flight; the block does
// not enforce this. retry_limit resets to 100 and a value of 0 behaves as 1.
module sd_card_init_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic        cmd_sent,
    input  logic        resp_end,
    input  logic        crc_fail,
    input  logic        timed_out,
    input  logic [31:0] resp_word0,
    input  logic [31:0] resp_word1,
    input  logic [31:0] resp_word2,
    input  logic [31:0] resp_word3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        cmd_valid,
    output logic [5:0]  cmd_index,
    output logic [31:0] cmd_arg,
    output logic [1:0]  resp_kind,
    output logic [1:0]  capture_kind,
    output logic        done_res,
    output logic        failed,
    output logic [1:0]  card_kind,
    output logic        block_addressing,
    output logic [15:0] card_address,
    output logic        wide_bus
);
    import sdis_pkg::*;

    logic [7:0] limit_reg;
    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;
    logic    fire;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= RETRY_LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.action     <= action;
            item_reg.cmd_sent   <= cmd_sent;
            item_reg.resp_end   <= resp_end;
            item_reg.crc_fail   <= crc_fail;
            item_reg.resp_word0 <= resp_word0;
        end
        if (fire)
            res_reg <= res_next;
    end

    sdis_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (fire),
        .item        (item_reg),
        .retry_limit (limit_reg),
        .res         (res_next)
    );

    assign out_valid        = out_valid_reg;
    assign cmd_valid        = res_reg.cmd_valid;
    assign cmd_index        = res_reg.cmd_index;
    assign cmd_arg          = res_reg.cmd_arg;
    assign resp_kind        = res_reg.resp_kind;
    assign capture_kind     = res_reg.capture_kind;
    assign done_res         = res_reg.done_res;
    assign failed           = res_reg.failed;
    assign card_kind        = res_reg.card_kind;
    assign block_addressing = res_reg.block_addressing;
    assign card_address     = res_reg.card_address;
    assign wide_bus         = res_reg.wide_bus;

    a_fail_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |-> done_res)
        else $error("failure reported without end of sequence");

    a_done_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !cmd_valid)
        else $error("command issued on the transfer that ends the sequence");

    a_idle_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cmd_valid) |->
            (cmd_index == '0 && cmd_arg == '0 && resp_kind == RESP_NONE))
        else $error("command fields not cleared without a command");

endmodule

### tb/sv/sd_card_init_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for sd_card_init_sequencer_unit: a card model answers each predicted command,
// and a scoreboard predicts and checks every result. Depends on sdis_pkg and the RTL.
module sd_card_init_sequencer_unit_tb;
    import sdis_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD0, S_CMD8, S_POLL2, S_PROBE, S_POLL1,
        S_CMD2, S_CMD3, S_CMD9, S_CMD7, S_CMD16, S_ACMD6
    } seq_phase_t;

    typedef struct {
        logic        action;
        logic        cmd_sent;
        logic        resp_end;
        logic        crc_fail;
        logic        timed_out;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } card_event_t;

    class next_cmd_board;
        logic [7:0]  limit;
        seq_phase_t  phase;
        bit          app_pending;
        logic [7:0]  attempts;
        logic [1:0]  kind;
        bit          blk;
        logic [15:0] rca;
        bit          use_cmd1;
        bit          wide;
        result_t     nxt;
        result_t     latest;
        result_t     pending_cmds[$];
        int          errors;
        int          checked;

        function new();
            limit = RETRY_LIMIT_RESET;
            errors = 0;
            checked = 0;
            clear_run();
            latest = '0;
        endfunction

        function void clear_run();
            phase = S_IDLE;
            app_pending = 0;
            attempts = 0;
            kind = KIND_UNKNOWN;
            blk = 0;
            rca = 0;
            use_cmd1 = 0;
            wide = 0;
        endfunction

        function void issue(logic [5:0] idx, logic [31:0] arg, logic [1:0] rk);
            nxt.cmd_valid = 1;
            nxt.cmd_index = idx;
            nxt.cmd_arg = arg;
            nxt.resp_kind = rk;
        endfunction

        function void issue_app(seq_phase_t ph);
            phase = ph;
            app_pending = 1;
            issue(CMD_APP, {rca, 16'h0}, RESP_SHORT);
        endfunction

        function void finish_run(bit fail);
            phase = S_IDLE;
            app_pending = 0;
            nxt.done_res = 1;
            nxt.failed = fail;
        endfunction

        function void next_poll();
            attempts = attempts + 8'd1;
            if (phase == S_POLL1 && use_cmd1)
                issue(CMD_SEND_OP, VOLT_WINDOW, RESP_SHORT);
            else
                issue_app(phase);
        endfunction

        function void retry_poll();
            // a limit of 0 behaves as 1: attempts is at least 1 here
            if (attempts >= limit)
                finish_run(1);
            else
                next_poll();
        endfunction

        function void advance(bit ok, logic [31:0] w0);
            bit sd;
            sd = (kind == KIND_SD1 || kind == KIND_SD2);
            case (phase)
                S_CMD0:
                begin
                    phase = S_CMD8;
                    issue(CMD_IF_COND, IF_COND_ARG, RESP_SHORT);
                end
                S_CMD8:
                    if (ok && w0[11:0] == IF_COND_ECHO)
                    begin
                        kind = KIND_SD2;
                        phase = S_POLL2;
                        attempts = 0;
                        next_poll();
                    end
                    else
                        issue_app(S_PROBE);
                S_PROBE:
                begin
                    kind = ok ? KIND_SD1 : KIND_MMC;
                    use_cmd1 = !ok;
                    phase = S_POLL1;
                    attempts = 0;
                    next_poll();
                end
                S_POLL2, S_POLL1:
                    if (ok && w0[OCR_BUSY_BIT])
                    begin
                        if (phase == S_POLL2)
                            blk = w0[OCR_CCS_BIT];
                        nxt.capture_kind = CAP_OCR;
                        phase = S_CMD2;
                        issue(CMD_ALL_CID, 32'h0, RESP_LONG);
                    end
                    else
                        retry_poll();
                S_CMD2:
                    if (!ok)
                        finish_run(1);
                    else
                    begin
                        nxt.capture_kind = CAP_CID;
                        phase = S_CMD3;
                        issue(CMD_SET_RCA, sd ? 32'h0 : {MMC_RCA, 16'h0}, RESP_SHORT);
                    end
                S_CMD3:
                    if (!ok)
                        finish_run(1);
                    else
                    begin
                        rca = sd ? w0[31:16] : MMC_RCA;
                        phase = S_CMD9;
                        issue(CMD_SEND_CSD, {rca, 16'h0}, RESP_LONG);
                    end
                S_CMD9:
                    if (!ok)
                        finish_run(1);
                    else
                    begin
                        nxt.capture_kind = CAP_CSD;
                        phase = S_CMD7;
                        issue(CMD_SELECT, {rca, 16'h0}, RESP_SHORT);
                    end
                S_CMD7:
                    if (!ok)
                        finish_run(1);
                    else if (!blk)
                    begin
                        phase = S_CMD16;
                        issue(CMD_BLOCKLEN, BLOCK_LEN_ARG, RESP_SHORT);
                    end
                    else if (sd)
                        issue_app(S_ACMD6);
                    else
                        finish_run(0);
                S_CMD16:
                    if (!ok || |(w0 & STATUS_ERR_MSK))
                        finish_run(1);
                    else if (sd)
                        issue_app(S_ACMD6);
                    else
                        finish_run(0);
                S_ACMD6:
                    if (!ok || |(w0 & STATUS_ERR_MSK))
                        finish_run(1);
                    else
                    begin
                        wide = 1;
                        finish_run(0);
                    end
                default:
                    phase = S_IDLE;
            endcase
        endfunction

        function void note_completion(card_event_t ev);
            bit ok;
            bit crc_tolerant;
            nxt = '0;
            if (ev.action == ACT_START)
            begin
                clear_run();
                phase = S_CMD0;
                issue(CMD_GO_IDLE, 32'h0, RESP_NONE);
            end
            else if (phase != S_IDLE)
            begin
                if (app_pending)
                begin
                    app_pending = 0;
                    if (ev.resp_end && ev.w0[APP_CMD_BIT])
                        issue(phase == S_ACMD6 ? CMD_BUS_WIDTH : CMD_SD_OP,
                              phase == S_POLL2 ? HCS_OP_ARG :
                              phase == S_ACMD6 ? BUS_4BIT_ARG : VOLT_WINDOW,
                              RESP_SHORT);
                    else
                        advance(0, ev.w0);
                end
                else
                begin
                    // CRC errors tolerated on CMD1 and ACMD41: probe and both polling phases
                    crc_tolerant = (phase == S_POLL2 || phase == S_PROBE || phase == S_POLL1);
                    if (phase == S_CMD0)
                        ok = ev.cmd_sent;
                    else
                        ok = ev.resp_end || (ev.crc_fail && crc_tolerant);
                    advance(ok, ev.w0);
                end
            end
            nxt.card_kind = kind;
            nxt.block_addressing = blk;
            nxt.card_address = rca;
            nxt.wide_bus = wide;
            latest = nxt;
            pending_cmds.push_back(nxt);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] exp);
            if (got !== exp)
                report($sformatf("result %0d %s got 0x%0h exp 0x%0h", checked, name, got, exp));
        endtask

        task check_cmd(result_t got);
            result_t exp;
            if (pending_cmds.size() == 0)
            begin
                report("result with no outstanding completion");
                return;
            end
            exp = pending_cmds.pop_front();
            check_field("cmd_valid", got.cmd_valid, exp.cmd_valid);
            check_field("cmd_index", got.cmd_index, exp.cmd_index);
            check_field("cmd_arg", got.cmd_arg, exp.cmd_arg);
            check_field("resp_kind", got.resp_kind, exp.resp_kind);
            check_field("capture_kind", got.capture_kind, exp.capture_kind);
            check_field("done_res", got.done_res, exp.done_res);
            check_field("failed", got.failed, exp.failed);
            check_field("card_kind", got.card_kind, exp.card_kind);
            check_field("block_addressing", got.block_addressing, exp.block_addressing);
            check_field("card_address", got.card_address, exp.card_address);
            check_field("wide_bus", got.wide_bus, exp.wide_bus);
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic        cmd_sent;
    logic        resp_end;
    logic        crc_fail;
    logic        timed_out;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic        out_valid;
    logic        out_stall;
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic [1:0]  capture_kind;
    logic        done_res;
    logic        failed;
    logic [1:0]  card_kind;
    logic        block_addressing;
    logic [15:0] card_address;
    logic        wide_bus;

    sd_card_init_sequencer_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .cmd_sent           (cmd_sent),
        .resp_end           (resp_end),
        .crc_fail           (crc_fail),
        .timed_out          (timed_out),
        .resp_word0         (resp_word0),
        .resp_word1         (resp_word1),
        .resp_word2         (resp_word2),
        .resp_word3         (resp_word3),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .cmd_valid          (cmd_valid),
        .cmd_index          (cmd_index),
        .cmd_arg            (cmd_arg),
        .resp_kind          (resp_kind),
        .capture_kind       (capture_kind),
        .done_res           (done_res),
        .failed             (failed),
        .card_kind          (card_kind),
        .block_addressing   (block_addressing),
        .card_address       (card_address),
        .wide_bus           (wide_bus)
    );

    localparam int CARD_SD2 = 0;
    localparam int CARD_SD1 = 1;
    localparam int CARD_MMC = 2;

    next_cmd_board board;
    bit            calm;
    int            card_prof;
    int            ready_after;
    bit            ccs_bit;
    int            fault_pct;
    int            polls_seen;
    int            card_runs;

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("timeout waiting for the sequencer");
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 6);

    always @(posedge clk)
    begin
        result_t got;
        got.cmd_valid = cmd_valid;
        got.cmd_index = cmd_index;
        got.cmd_arg = cmd_arg;
        got.resp_kind = resp_kind;
        got.capture_kind = capture_kind;
        got.done_res = done_res;
        got.failed = failed;
        got.card_kind = card_kind;
        got.block_addressing = block_addressing;
        got.card_address = card_address;
        got.wide_bus = wide_bus;
        if (rst_n && out_valid && !out_stall)
            board.check_cmd(got);
    end

    function automatic card_event_t make_event(logic act, logic sent, logic rend,
                                               logic crcf, logic tout, logic [31:0] w0);
        card_event_t ev;
        ev.action = act;
        ev.cmd_sent = sent;
        ev.resp_end = rend;
        ev.crc_fail = crcf;
        ev.timed_out = tout;
        ev.w0 = w0;
        ev.w1 = $urandom;
        ev.w2 = $urandom;
        ev.w3 = $urandom;
        return ev;
    endfunction

    function automatic card_event_t noise_event(logic act);
        return make_event(act, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
    endfunction

    function automatic void new_card(int prof, int ready, bit ccs, int fault);
        card_prof = prof;
        ready_after = ready;
        ccs_bit = ccs;
        fault_pct = fault;
        polls_seen = 0;
        card_runs++;
    endfunction

    function automatic card_event_t start_event();
        new_card($urandom_range(2),
                 ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(260),
                 1'($urandom_range(1)),
                 ($urandom_range(9) < 7) ? 0 : $urandom_range(5, 20));
        return noise_event(ACT_START);
    endfunction

    // Answer the command the sequencer just issued, as a card of the current profile would
    function automatic card_event_t card_reply();
        card_event_t ev;
        ev = make_event(ACT_COMPLETE, 0, 0, 0, 0, $urandom);
        case (board.latest.cmd_index)
            CMD_GO_IDLE:
                ev.cmd_sent = 1;
            CMD_IF_COND:
                if (card_prof == CARD_SD2)
                begin
                    ev.resp_end = 1;
                    ev.w0[11:0] = IF_COND_ECHO;
                end
                else if ($urandom_range(1))
                    ev.timed_out = 1;
                else
                    ev.resp_end = 1;
            CMD_APP:
                if (card_prof == CARD_MMC)
                    ev.timed_out = 1;
                else
                begin
                    ev.resp_end = 1;
                    ev.w0[APP_CMD_BIT] = 1;
                end
            CMD_SD_OP, CMD_SEND_OP:
                if (card_prof == CARD_MMC && board.latest.cmd_index == CMD_SD_OP)
                    ev.timed_out = 1;
                else
                begin
                    polls_seen++;
                    if ($urandom_range(1))
                        ev.resp_end = 1;
                    else
                        ev.crc_fail = 1;
                    ev.w0[OCR_BUSY_BIT] = polls_seen > ready_after;
                    ev.w0[OCR_CCS_BIT] = ccs_bit;
                end
            CMD_BLOCKLEN, CMD_BUS_WIDTH:
            begin
                ev.resp_end = 1;
                ev.w0 = ev.w0 & ~STATUS_ERR_MSK;
            end
            default:
                ev.resp_end = 1;
        endcase
        if ($urandom_range(99) < fault_pct)
            ev = noise_event(ACT_COMPLETE);
        return ev;
    endfunction

    function automatic card_event_t next_event();
        if (board.phase == S_IDLE)
            return ($urandom_range(9) != 0) ? start_event() : noise_event(ACT_COMPLETE);
        else if ($urandom_range(99) < 2)
            return start_event();
        return card_reply();
    endfunction

    // Starts and ends at a falling edge; the transfer is noted at the edge that takes it
    task automatic send_item(card_event_t ev);
        if (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1;
        action <= ev.action;
        cmd_sent <= ev.cmd_sent;
        resp_end <= ev.resp_end;
        crc_fail <= ev.crc_fail;
        timed_out <= ev.timed_out;
        resp_word0 <= ev.w0;
        resp_word1 <= ev.w1;
        resp_word2 <= ev.w2;
        resp_word3 <= ev.w3;
        do
            @(posedge clk);
        while (in_stall);
        board.note_completion(ev);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending_cmds.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_limit(logic [7:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        board.limit = v;
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    initial
    begin
        int          limits[5];
        int          sent;
        bit          counts;
        card_event_t ev;

        clk = 0;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        in_valid = 0;
        action = ACT_START;
        cmd_sent = 0;
        resp_end = 0;
        crc_fail = 0;
        timed_out = 0;
        resp_word0 = 0;
        resp_word1 = 0;
        resp_word2 = 0;
        resp_word3 = 0;
        out_stall = 0;
        calm = 0;
        card_runs = 0;
        board = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // completion before any start is ignored
        send_item(make_event(ACT_COMPLETE, 1, 1, 1, 1, 32'hFFFF_FFFF));

        // SD v2, byte addressed, one busy poll: full path through CMD16 and ACMD6
        new_card(CARD_SD2, 1, 0, 0);
        send_item(make_event(ACT_START, 0, 0, 0, 0, 32'h0));
        while (board.phase != S_IDLE)
            send_item(card_reply());

        // bad echo, CMD55 without APP_CMD -> MMC; CRC error tolerated on CMD1 but not CMD2
        new_card(CARD_MMC, 0, 1, 0);
        send_item(make_event(ACT_START, 1, 1, 1, 1, 32'hFFFF_FFFF));
        send_item(make_event(ACT_COMPLETE, 0, 0, 0, 0, 32'h0));
        send_item(make_event(ACT_COMPLETE, 0, 1, 0, 0, 32'hFFFF_F000));
        send_item(make_event(ACT_COMPLETE, 0, 1, 0, 0, 32'hFFFF_FFDF));
        send_item(make_event(ACT_COMPLETE, 0, 0, 1, 0, 32'h8000_0000));
        send_item(make_event(ACT_COMPLETE, 0, 0, 1, 1, 32'hFFFF_FFFF));
        drain();

        limits = '{1, 255, 100, 2, 0};
        limits[4] = $urandom_range(3, 254);
        foreach (limits[p])
        begin
            write_limit(8'(limits[p]));
            calm = (p == 2);
            sent = 0;
            while (sent < 230)
            begin
                ev = next_event();
                counts = (ev.action == ACT_START) || (board.phase != S_IDLE);
                send_item(ev);
                if (counts)
                    sent++;
            end
            drain();
        end

        $display("%0d card runs driven, %0d results checked", card_runs, board.checked);
        $display("retry limits 1, 2, 100, 255 and %0d; %0d mismatches",
                 limits[4], board.errors);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### sim.f
design/sdis_pkg.sv
design/sdis_core.sv
design/sd_card_init_sequencer_unit.sv
tb/sv/sd_card_init_sequencer_unit_tb.sv
